// ===== rtl/rbdg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbdg_pkg
// Shared constants for the RGB box downscaler: field widths, register
// indexes and default sizing.
// ----------------------------------------------------------------------------
package rbdg_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 16;
  localparam int MAX_HEIGHT    = 4096;

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 10;   // sum of three channel bytes
  localparam int GRAY_W   = 8;
  localparam int BCOL_W   = 10;
  localparam int BROW_W   = 12;
  localparam int ROW_W    = 12;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int SCALE_W  = 5;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = 5'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

endpackage
`default_nettype wire

// ===== rtl/rgb_box_downscale_gray.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_box_downscale_gray
// Box-filter downscaler: sums the BGR bytes of each scale x scale block in a
// one-row accumulator RAM and emits floor(sum / (3*scale*scale)) per block.
// ----------------------------------------------------------------------------
// Pixels that do not close a block are taken back to back (RAM read on
//   accept, add and write-back next cycle, same-entry hazard forwarded).
// A block-closing pixel holds the input through write-back, the restoring
//   divider (one quotient bit per cycle) and an output load that waits on a stalled output.
// Reset and any scale, width or height write: RAM clear of all MAX_WIDTH entries, input not ready.
// ----------------------------------------------------------------------------
module rgb_box_downscale_gray #(
  parameter int MAX_WIDTH = rbdg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = rbdg_pkg::MAX_SCALE_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // config
  input  wire                                 cfg_we,
  input  wire  [rbdg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [rbdg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel in
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [rbdg_pkg::IN_TDATA_W-1:0]     in_tdata,   // blue, green, red
  // block out
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [rbdg_pkg::OUT_TDATA_W-1:0]    out_tdata,  // gray_level, block_col, block_row
  output logic                                out_tlast   // frame_done
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int SW  = $clog2(765 * MAX_SCALE * MAX_SCALE + 1);
  localparam int DW  = $clog2(3 * MAX_SCALE * MAX_SCALE + 1);
  localparam int QW  = rbdg_pkg::GRAY_W;
  localparam int CNW = $clog2(QW);
  localparam int DSW = DW + QW - 1;
  localparam int RW  = (SW > DSW) ? SW : DSW;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_RUN   = 4'b0010,
    S_DIV   = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [rbdg_pkg::SCALE_W-1:0]  cfg_scale_r;
  logic [rbdg_pkg::WIDTH_W-1:0]  cfg_width_r;
  logic [rbdg_pkg::HEIGHT_W-1:0] cfg_height_r;

  logic [SCW-1:0]                s_eff;
  logic [WW-1:0]                 w_eff;
  logic [rbdg_pkg::HEIGHT_W-1:0] h_eff;
  logic [DW-1:0]                 d_eff;

  logic [AW-1:0]               clr_cnt_r;
  logic [AW-1:0]               col_r, col_nxt;
  logic [AW-1:0]               bcol_r, bcol_nxt;
  logic [SCW-1:0]              scol_r, scol_nxt;
  logic [rbdg_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [rbdg_pkg::BROW_W-1:0] brow_r, brow_nxt;
  logic [SCW-1:0]              srow_r, srow_nxt;

  logic last_x, last_y, close_x, close_y, scol_wrap, srow_wrap;
  logic accept, cfg_hit;

  logic                        acc_v_r;
  logic [rbdg_pkg::PIX_W-1:0]  acc_pix_r;
  logic [AW-1:0]               acc_addr_r;
  logic                        acc_close_r;
  logic                        acc_last_r;
  logic [rbdg_pkg::BROW_W-1:0] acc_brow_r;
  logic                        acc_fwd_r;
  logic [SW-1:0]               fwd_sum_r;
  logic [SW-1:0]               acc_sum;

  logic [SW-1:0] mem [MAX_WIDTH];
  logic [SW-1:0] mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;

  logic [RW-1:0]  div_rem_r;
  logic [RW-1:0]  div_dsh_r;
  logic [QW-1:0]  div_q_r;
  logic [CNW-1:0] div_cnt_r;
  logic           div_ge;

  logic                        out_valid_r;
  logic [rbdg_pkg::GRAY_W-1:0] out_gray_r;
  logic [rbdg_pkg::BCOL_W-1:0] out_bcol_r;
  logic [rbdg_pkg::BROW_W-1:0] out_brow_r;
  logic                        out_last_r;
  logic                        out_load;

  // effective register values
  always_comb begin
    if (cfg_scale_r == '0) begin
      s_eff = SCW'(1);
    end else if (32'(cfg_scale_r) > 32'(MAX_SCALE)) begin
      s_eff = SCW'(MAX_SCALE);
    end else begin
      s_eff = SCW'(cfg_scale_r);
    end
    if (cfg_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = rbdg_pkg::HEIGHT_W'(1);
    end else if (32'(cfg_height_r) > 32'(rbdg_pkg::MAX_HEIGHT)) begin
      h_eff = rbdg_pkg::HEIGHT_W'(rbdg_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_r;
    end
  end

  assign d_eff = DW'(DW'(s_eff) * DW'(s_eff) * DW'(3));

  assign cfg_hit = cfg_we && (cfg_index == rbdg_pkg::CFG_SCALE ||
                              cfg_index == rbdg_pkg::CFG_WIDTH ||
                              cfg_index == rbdg_pkg::CFG_HEIGHT);

  assign in_tready = (state_r == S_RUN) && !(acc_v_r && acc_close_r);
  assign accept    = in_tvalid && in_tready;

  // position tracking
  assign last_x    = (WW'(col_r) == w_eff - WW'(1));
  assign last_y    = (rbdg_pkg::HEIGHT_W'(row_r) == h_eff - rbdg_pkg::HEIGHT_W'(1));
  assign scol_wrap = (scol_r == s_eff - SCW'(1));
  assign srow_wrap = (srow_r == s_eff - SCW'(1));
  assign close_x   = last_x || scol_wrap;
  assign close_y   = last_y || srow_wrap;

  always_comb begin
    col_nxt  = col_r;
    bcol_nxt = bcol_r;
    scol_nxt = scol_r;
    row_nxt  = row_r;
    brow_nxt = brow_r;
    srow_nxt = srow_r;
    if (last_x) begin
      col_nxt  = '0;
      bcol_nxt = '0;
      scol_nxt = '0;
      if (last_y) begin
        row_nxt  = '0;
        brow_nxt = '0;
        srow_nxt = '0;
      end else begin
        row_nxt  = row_r + 1'b1;
        brow_nxt = srow_wrap ? brow_r + 1'b1 : brow_r;
        srow_nxt = srow_wrap ? '0 : srow_r + 1'b1;
      end
    end else begin
      col_nxt  = col_r + 1'b1;
      bcol_nxt = scol_wrap ? bcol_r + 1'b1 : bcol_r;
      scol_nxt = scol_wrap ? '0 : scol_r + 1'b1;
    end
  end

  // accumulate stage
  assign acc_sum = (acc_fwd_r ? fwd_sum_r : mem_rdata_r) + SW'(acc_pix_r);

  assign mem_we    = (state_r == S_CLEAR) || ((state_r == S_RUN) && acc_v_r);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : acc_addr_r;
  assign mem_wdata = ((state_r == S_CLEAR) || acc_close_r) ? '0 : acc_sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[bcol_r];
  end

  // divider
  assign div_ge = (div_rem_r >= div_dsh_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(MAX_WIDTH - 1)) state_nxt = S_RUN;
      S_RUN:   if (acc_v_r && acc_close_r) state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == '0) state_nxt = S_SEND;
      S_SEND:  if (!out_valid_r || out_tready) state_nxt = S_RUN;
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_hit) begin
      state_nxt = S_CLEAR;
    end
  end

  assign out_load = (state_r == S_SEND) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      cfg_scale_r  <= rbdg_pkg::SCALE_RST;
      cfg_width_r  <= rbdg_pkg::WIDTH_RST;
      cfg_height_r <= rbdg_pkg::HEIGHT_RST;
      col_r        <= '0;
      bcol_r       <= '0;
      scol_r       <= '0;
      row_r        <= '0;
      brow_r       <= '0;
      srow_r       <= '0;
      acc_v_r      <= 1'b0;
      acc_fwd_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rbdg_pkg::CFG_SCALE:  cfg_scale_r  <= rbdg_pkg::SCALE_W'(cfg_wdata);
          rbdg_pkg::CFG_WIDTH:  cfg_width_r  <= rbdg_pkg::WIDTH_W'(cfg_wdata);
          rbdg_pkg::CFG_HEIGHT: cfg_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        clr_cnt_r <= '0;
        col_r     <= '0;
        bcol_r    <= '0;
        scol_r    <= '0;
        row_r     <= '0;
        brow_r    <= '0;
        srow_r    <= '0;
        acc_v_r   <= 1'b0;
        acc_fwd_r <= 1'b0;
      end else begin
        if (state_r == S_CLEAR) begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        acc_v_r <= accept;
        if (accept) begin
          col_r     <= col_nxt;
          bcol_r    <= bcol_nxt;
          scol_r    <= scol_nxt;
          row_r     <= row_nxt;
          brow_r    <= brow_nxt;
          srow_r    <= srow_nxt;
          acc_fwd_r <= acc_v_r && (acc_addr_r == bcol_r);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_pix_r   <= rbdg_pkg::PIX_W'(in_tdata[7:0]) + rbdg_pkg::PIX_W'(in_tdata[15:8])
                   + rbdg_pkg::PIX_W'(in_tdata[23:16]);
      acc_addr_r  <= bcol_r;
      acc_close_r <= close_x && close_y;
      acc_last_r  <= last_x && last_y;
      acc_brow_r  <= brow_r;
      fwd_sum_r   <= acc_sum;
    end
    if ((state_r == S_RUN) && acc_v_r && acc_close_r) begin
      div_rem_r <= RW'(acc_sum);
      div_dsh_r <= RW'(d_eff) << (QW - 1);
      div_q_r   <= '0;
      div_cnt_r <= CNW'(QW - 1);
    end else if (state_r == S_DIV) begin
      div_rem_r <= div_ge ? div_rem_r - div_dsh_r : div_rem_r;
      div_dsh_r <= div_dsh_r >> 1;
      div_q_r   <= {div_q_r[QW-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (out_load) begin
      out_gray_r <= div_q_r;
      out_bcol_r <= rbdg_pkg::BCOL_W'(acc_addr_r);
      out_brow_r <= acc_brow_r;
      out_last_r <= acc_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rbdg_pkg::OUT_TDATA_W - rbdg_pkg::GRAY_W - rbdg_pkg::BCOL_W
                         - rbdg_pkg::BROW_W){1'b0}}, out_brow_r, out_bcol_r, out_gray_r};
  assign out_tlast  = out_last_r;

  // checks
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    acc_v_r && acc_fwd_r |-> $past(mem_we && mem_waddr == acc_addr_r))
    else $error("forwarded sum without matching write-back");

  a_quot_fit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEND |-> div_rem_r < RW'(d_eff))
    else $error("block quotient exceeds gray range");

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !acc_v_r)
    else $error("pixel in flight during RAM clear");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SEND))
    else $error("output loaded outside send state");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_box_downscale_gray. A behavioral box-sum model
// predicts every block result from the accepted pixels and the register
// writes. The run covers reset sizes, clamped and saturated register values,
// a write to the unused index in mid-frame, a long row at the saturated
// width, and then random frame geometries. The pixel stream gets random gaps
// and the block stream gets random stalls.
// ----------------------------------------------------------------------------
module testbench;
  import rbdg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_GAP       = 14;
  localparam int DRAIN_CYCLES  = 16;
  localparam int ROW_PIXELS    = 256;
  localparam int RANDOM_PIXELS = 220;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [GRAY_W-1:0] gray_level;
    logic [BCOL_W-1:0] block_col;
    logic [BROW_W-1:0] block_row;
    logic              frame_done;
  } block_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // blue, green, red
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // gray_level, block_col, block_row
  logic                   out_tlast;  // frame_done

  // predictor state
  block_result_t       pending_blocks[$];
  int unsigned         block_sum[MAX_WIDTH_DEF];
  logic [SCALE_W-1:0]  scale_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         pix_col;
  int unsigned         pix_row;

  bit     gaps_on;
  int     mismatches = 0;
  longint cycles = 0;

  rgb_box_downscale_gray u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    foreach (block_sum[i]) block_sum[i] = 0;
    pix_col = 0;
    pix_row = 0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SCALE:  scale_reg  = val[SCALE_W-1:0];
      CFG_WIDTH:  width_reg  = val[WIDTH_W-1:0];
      CFG_HEIGHT: height_reg = val[HEIGHT_W-1:0];
      default:    return;
    endcase
    restart_frame();
  endfunction

  function automatic void accumulate_pixel(logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                                           logic [CHAN_W-1:0] r);
    int unsigned   s, w, h, bc;
    logic          last_x, last_y;
    block_result_t blk;
    s = clamp_size(32'(scale_reg), MAX_SCALE_DEF);
    w = clamp_size(32'(width_reg), MAX_WIDTH_DEF);
    h = clamp_size(32'(height_reg), MAX_HEIGHT);
    if (pix_col >= w || pix_row >= h) restart_frame();
    bc = (pix_col / s) % MAX_WIDTH_DEF;
    block_sum[bc] += 32'(b) + 32'(g) + 32'(r);
    last_x = (pix_col == w - 1);
    last_y = (pix_row == h - 1);
    if ((last_x || pix_col % s == s - 1) && (last_y || pix_row % s == s - 1)) begin
      blk.gray_level = GRAY_W'(block_sum[bc] / (3 * s * s));
      blk.block_col  = BCOL_W'(bc);
      blk.block_row  = BROW_W'(pix_row / s);
      blk.frame_done = last_x && last_y;
      pending_blocks.push_back(blk);
      block_sum[bc] = 0;
    end
    if (last_x) begin
      pix_col = 0;
      pix_row = last_y ? 0 : pix_row + 1;
    end else begin
      pix_col++;
    end
  endfunction

  task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, g, b};
    do @(posedge clk); while (!in_tready);
    accumulate_pixel(b, g, r);
  endtask

  task automatic send_random_pixel();
    logic [IN_TDATA_W-1:0] px;
    case ($urandom_range(0, 15))
      0:       px = '0;
      1, 2:    px = '1;
      default: px = IN_TDATA_W'($urandom());
    endcase
    send_pixel(px[7:0], px[15:8], px[23:16]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] w,
                          input logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_SCALE, s);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // drain outstanding blocks, then let a non-closing pixel finish its write-back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h3c, 8'ha5, 8'h5a);
    wait_idle();
  endtask

  // zero sizes act as 1: every pixel is a whole frame
  task automatic test_minimum_size();
    set_size(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(0));
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h7f, 8'h01);
    wait_idle();
  endtask

  task automatic test_unused_index();
    set_size(CFG_DATA_W'(3), CFG_DATA_W'(4), CFG_DATA_W'(2));
    repeat (4) send_random_pixel();
    wait_idle();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    repeat (4) send_random_pixel();
    wait_idle();
  endtask

  task automatic test_saturation();
    set_size(13'h1fff, CFG_DATA_W'(1), 13'h1fff);
    repeat (16) send_random_pixel();
    wait_idle();
  endtask

  task automatic test_wide_row();
    gaps_on = 1'b0;
    set_size(CFG_DATA_W'(16), 13'h1fff, CFG_DATA_W'(0));
    repeat (ROW_PIXELS) send_random_pixel();
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned           frame_px, count;
    int                    sent;
    logic [CFG_DATA_W-1:0] val;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
      if ($urandom_range(0, 5) != 0) begin
        val = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 9))
          0:       val[SCALE_W-1:0] = '0;
          1:       val[SCALE_W-1:0] = SCALE_W'($urandom_range(16, 31));
          2, 3:    val[SCALE_W-1:0] = SCALE_W'($urandom_range(5, 16));
          default: val[SCALE_W-1:0] = SCALE_W'($urandom_range(1, 4));
        endcase
        write_reg(CFG_SCALE, val);
      end
      if ($urandom_range(0, 5) != 0) begin
        val = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 9))
          0:       val[WIDTH_W-1:0] = '0;
          1:       val[WIDTH_W-1:0] = WIDTH_W'($urandom_range(1024, 2047));
          default: val[WIDTH_W-1:0] = WIDTH_W'($urandom_range(1, 24));
        endcase
        write_reg(CFG_WIDTH, val);
      end
      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = CFG_DATA_W'($urandom_range(4096, 8191));
          default: val = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        write_reg(CFG_HEIGHT, val);
      end
      frame_px = clamp_size(32'(width_reg), MAX_WIDTH_DEF) *
                 clamp_size(32'(height_reg), MAX_HEIGHT);
      if (frame_px <= 64) begin
        count = frame_px * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) count -= $urandom_range(0, frame_px - 1);
      end else begin
        count = $urandom_range(16, 120);
      end
      repeat (count) send_random_pixel();
      sent += count;
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  // block stream back-pressure
  initial begin : block_ready
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_blocks
    block_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.gray_level = out_tdata[7:0];
      got.block_col  = out_tdata[17:8];
      got.block_row  = out_tdata[29:18];
      got.frame_done = out_tlast;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected block: gray %0d col %0d row %0d last %0b",
                   got.gray_level, got.block_col, got.block_row, got.frame_done);
      end else begin
        want = pending_blocks.pop_front();
        if (got.gray_level !== want.gray_level || got.block_col !== want.block_col ||
            got.block_row !== want.block_row || got.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("block mismatch: exp gray %0d col %0d row %0d last %0b, %s",
                     want.gray_level, want.block_col, want.block_row, want.frame_done,
                     $sformatf("got gray %0d col %0d row %0d last %0b", got.gray_level,
                               got.block_col, got.block_row, got.frame_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rgb_box_downscale_gray verification failed");
      $finish;
    end
  end

  initial begin : main
    gaps_on    = 1'b1;
    scale_reg  = SCALE_RST;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    restart_frame();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SCALE;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_minimum_size();
    test_unused_index();
    test_saturation();
    test_wide_row();
    test_random_frames();
    wait_idle();

    if (pending_blocks.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("rgb_box_downscale_gray verification clean");
    end else begin
      $display("rgb_box_downscale_gray verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rbdg_pkg.sv
rtl/rgb_box_downscale_gray.sv
test/testbench.sv
